// ===== src/min_priority_process_queue_assert.svh =====
// Assertion macros shared by the priority queue modules.
`ifndef MIN_PRIORITY_PROCESS_QUEUE_ASSERT_SVH
`define MIN_PRIORITY_PROCESS_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MPQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mpq_pkg.sv =====
// Types and codes shared by the priority queue modules.
package mpq_pkg;

  localparam int unsigned HandleW = 8;
  localparam int unsigned PrioW   = 8;
  localparam int unsigned CountW  = 5;

  typedef enum logic [1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_REM = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [HandleW-1:0]   proc_handle;
    logic [PrioW-1:0]     priority_req;
  } req_t;

  typedef struct packed {
    logic [HandleW-1:0]   out_handle;
    logic                 out_valid;
    status_t              status;
    logic [CountW-1:0]    count;
    logic                 is_empty;
  } rsp_t;

  typedef struct packed {
    logic [HandleW-1:0]   handle;
    logic [PrioW-1:0]     prio;
  } entry_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic accept;
    logic scan_en;
    logic start_shift;
    logic shift_en;
    logic commit;
  } ctl_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic scan_needed;
    logic scan_last;
    logic hit;
    logic shift_idle;
    logic out_free;
  } sts_t;

endpackage

// ===== src/mpq_chan_if.sv =====
// Request and response channel interfaces for the priority queue.
interface mpq_req_if import mpq_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mpq_rsp_if import mpq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/mpq_datapath.sv =====
// Entry memory, scan/compact pointers, best-entry tracking and result register.
`include "min_priority_process_queue_assert.svh"

module mpq_datapath import mpq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  ctl_t ctl_i,
  output sts_t sts_o,
  input  req_t req_i,
  output rsp_t rsp_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  entry_t          rdata_r;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;

  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   ptr_r, ptr_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]   rd_idx_r, rd_idx_nxt;
  req_t            req_r, req_nxt;
  logic [AW-1:0]   best_idx_r, best_idx_nxt;
  logic [PrioW-1:0] best_prio_r, best_prio_nxt;
  logic [HandleW-1:0] best_handle_r, best_handle_nxt;
  logic            found_r, found_nxt;
  rsp_t            out_r, out_nxt;
  logic            out_vld_r, out_vld_nxt;

  logic            issue;
  logic            cmp_en;
  logic            take;
  logic            full;
  logic            shift_wr;
  logic            enq_wr;

  assign full     = (count_r == CW'(DEPTH));
  assign issue    = (ctl_i.scan_en || ctl_i.shift_en) && (ptr_r < count_r);
  assign cmp_en   = ctl_i.scan_en && rd_vld_r;
  assign shift_wr = ctl_i.shift_en && rd_vld_r;
  assign enq_wr   = ctl_i.commit && (req_r.cmd == CMD_ENQ) && !full;
  assign rd_addr  = ptr_r[AW-1:0];

  // Dequeue keeps the strictly smaller priority, so ties stay with the earlier entry.
  always_comb begin
    case (req_r.cmd)
      CMD_DEQ: take = !found_r || (rdata_r.prio < best_prio_r);
      CMD_REM: take = !found_r && (rdata_r.handle == req_r.proc_handle);
      default: take = 1'b0;
    endcase
  end

  // Single write port: enqueue at the tail, or compaction one slot down.
  always_comb begin
    wr_en   = enq_wr || shift_wr;
    wr_addr = shift_wr ? (rd_idx_r - AW'(1)) : count_r[AW-1:0];
    wr_data = shift_wr ? rdata_r
                       : entry_t'{handle: req_r.proc_handle, prio: req_r.priority_req};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    req_nxt         = ctl_i.accept ? req_i : req_r;
    rd_vld_nxt      = issue;
    rd_idx_nxt      = ptr_r[AW-1:0];
    found_nxt       = found_r;
    best_idx_nxt    = best_idx_r;
    best_prio_nxt   = best_prio_r;
    best_handle_nxt = best_handle_r;
    if (ctl_i.accept) begin
      found_nxt = 1'b0;
    end else if (cmp_en && take) begin
      found_nxt       = 1'b1;
      best_idx_nxt    = rd_idx_r;
      best_prio_nxt   = rdata_r.prio;
      best_handle_nxt = rdata_r.handle;
    end

    if (ctl_i.accept) begin
      ptr_nxt = '0;
    end else if (ctl_i.start_shift) begin
      ptr_nxt = CW'(best_idx_nxt) + CW'(1);
    end else if (issue) begin
      ptr_nxt = ptr_r + CW'(1);
    end else begin
      ptr_nxt = ptr_r;
    end
  end

  // Result assembly and count update at commit.
  always_comb begin
    count_nxt = count_r;
    out_nxt   = out_r;
    if (ctl_i.commit) begin
      out_nxt.out_handle = '0;
      out_nxt.out_valid  = 1'b0;
      case (req_r.cmd)
        CMD_ENQ: begin
          out_nxt.status = full ? STAT_FULL : STAT_OK;
          if (!full) begin
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_DEQ: begin
          out_nxt.status = found_r ? STAT_OK : STAT_EMPTY;
          if (found_r) begin
            count_nxt          = count_r - CW'(1);
            out_nxt.out_handle = best_handle_r;
            out_nxt.out_valid  = 1'b1;
          end
        end
        CMD_REM: begin
          out_nxt.status = found_r ? STAT_OK : STAT_NOTFOUND;
          if (found_r) begin
            count_nxt = count_r - CW'(1);
          end
        end
        default: out_nxt.status = STAT_OK;
      endcase
      out_nxt.count    = CountW'(count_nxt);
      out_nxt.is_empty = (count_nxt == '0);
    end
    out_vld_nxt = ctl_i.commit ? 1'b1 : ((out_vld_r && rsp_ready_i) ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      ptr_r     <= '0;
      rd_vld_r  <= 1'b0;
      found_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      ptr_r     <= ptr_nxt;
      rd_vld_r  <= rd_vld_nxt;
      found_r   <= found_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    rd_idx_r      <= rd_idx_nxt;
    best_idx_r    <= best_idx_nxt;
    best_prio_r   <= best_prio_nxt;
    best_handle_r <= best_handle_nxt;
    out_r         <= out_nxt;
  end

  always_comb begin
    sts_o.scan_needed = (req_i.cmd inside {CMD_DEQ, CMD_REM}) && (count_r != '0);
    sts_o.scan_last   = cmp_en && (CW'(rd_idx_r) == (count_r - CW'(1)));
    sts_o.hit         = found_nxt;
    sts_o.shift_idle  = !rd_vld_r && !(ptr_r < count_r);
    sts_o.out_free    = !out_vld_r || rsp_ready_i;
  end

  assign rsp_o       = out_r;
  assign rsp_valid_o = out_vld_r;

  `MPQ_ASSERT_SAME(a_count_in_range, 1'b1, count_r <= CW'(DEPTH), "entry count above depth")
  `MPQ_ASSERT_NEXT(a_enq_grows, enq_wr, count_r == $past(count_r) + CW'(1),
                   "enqueue did not grow the count")
  `MPQ_ASSERT_SAME(a_shift_in_range, shift_wr, CW'(rd_idx_r) < count_r,
                   "compaction write outside held entries")

endmodule

// ===== src/mpq_ctrl.sv =====
// Sequencer for accept, scan, compaction and result commit.
`include "min_priority_process_queue_assert.svh"

module mpq_ctrl import mpq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid_i) begin
          state_nxt = sts_i.scan_needed ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_last) begin
          state_nxt = sts_i.hit ? S_SHIFT : S_DONE;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_idle) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = (state_r == S_IDLE);
    ctl_o.accept      = (state_r == S_IDLE) && in_valid_i;
    ctl_o.scan_en     = (state_r == S_SCAN);
    ctl_o.start_shift = (state_r == S_SCAN) && sts_i.scan_last && sts_i.hit;
    ctl_o.shift_en    = (state_r == S_SHIFT);
    ctl_o.commit      = (state_r == S_DONE) && sts_i.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `MPQ_ASSERT_NEXT(a_accept_leaves_idle, ctl_o.accept, state_r != S_IDLE,
                   "accepted transaction left controller idle")
  `MPQ_ASSERT_NEXT(a_commit_to_idle, ctl_o.commit, state_r == S_IDLE,
                   "controller did not return to idle after commit")
  `MPQ_ASSERT_NEXT(a_shift_from_scan, state_r != S_SCAN && state_r != S_SHIFT,
                   state_r != S_SHIFT, "compaction entered without a scan")

endmodule

// ===== src/min_priority_process_queue.sv =====
// Top level of the min-priority process queue.
// Usage:
//   in_chan carries one command transaction: cmd (enqueue, dequeue-min, remove
//   by handle, or no-op), proc_handle and priority_req. out_chan returns exactly
//   one result transaction per command: out_handle/out_valid for a dequeue,
//   status, count and is_empty after the command.
// Sequence (n = entries held, p = slot of the chosen entry):
//   enqueue / no-op / empty dequeue / empty remove: accept, then commit.
//   dequeue and remove: accept, a scan of all n held entries, then compaction
//   when an entry is taken (the entries above slot p move one slot down, none
//   for the last slot), then commit. The scan and the compaction share the one
//   read port of the entry memory; the compaction and an enqueue share its one
//   write port. One command is in flight at a time; the next is taken once the
//   previous result sits in the output register.
// Reset: rst_n (synchronous, active low) empties the queue and drops any
//   pending result; no clearing pass is needed, stored entries beyond the count
//   are never read.
// Stall: a result held in the output register waits for out_chan.ready; a
//   finished command then waits in its commit step and in_chan.ready stays low.
module min_priority_process_queue import mpq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mpq_req_if.sink    in_chan,
  mpq_rsp_if.source  out_chan
);

  // Command/status bundles between sequencer and datapath.
  ctl_t ctl;
  sts_t sts;

  mpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_chan.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Entry memory, scan pointer, best-entry registers and output register.
  mpq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .req_i       (in_chan.data),
    .rsp_o       (out_chan.data),
    .rsp_valid_o (out_chan.valid),
    .rsp_ready_i (out_chan.ready)
  );

endmodule
